@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the tag translator.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/mtat_pkg.sv @@
// Shared types, constants and lookup functions of the tag translator.
// Has no dependencies; used by mtat_ctrl, mtat_dp and the top level.
`default_nettype none

package mtat_pkg;

  localparam int HOLD_DEPTH_DEF = 16;
  localparam int MAX_RESULTS    = 32;
  localparam int RES_CW         = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = CFG_IDX_W'(1);

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;

  localparam logic [7:0] BANNER [8] = '{8'h54, 8'h6F, 8'h62, 8'h69,
                                        8'h6E, 8'h4D, 8'h55, 8'h44};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] total_length;
  } out_item_t;

  typedef enum logic [2:0] {
    TAG_UNKNOWN,
    TAG_NAME,
    TAG_COLOR,
    TAG_BOLD,
    TAG_RESET
  } tag_cls_t;

  typedef enum logic [1:0] {
    BLK_NAME,
    BLK_COLOR,
    BLK_BOLD,
    BLK_RESET
  } blk_kind_t;

  typedef enum logic [2:0] {
    LIT_LT,
    LIT_GT,
    LIT_TAG,
    LIT_W0,
    LIT_W1
  } lit_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     win_store;
    logic     win_shift;
    logic     tag_latch;
    logic     lit_load;
    lit_sel_t lit_sel;
    logic     lit_commit;
    logic     held_push;
    logic     flush_put;
    logic     flush_done;
    logic     blk_start;
    logic     blk_final;
    logic     blk_commit;
    logic     blk_put;
    logic     lit_put;
    logic     color_update;
    logic     end_put;
  } cmd_t;

  typedef struct packed {
    logic [1:0] wcnt;
    logic       win_tag;
    logic       last;
    tag_cls_t   tag_cls;
    logic       color_en;
    logic       lit_fits;
    logic       lit_break;
    logic       held_full;
    logic       held_pending;
    logic       blk_fits;
    logic       blk_last;
    logic       reset_fits;
    logic       out_free;
  } stat_t;

  function automatic tag_cls_t tag_classify(logic [7:0] t);
    tag_cls_t c;
    case (t)
      "h", "H": c = TAG_NAME;
      "r", "R", "g", "G", "b", "B", "y", "o", "Y", "O",
      "p", "m", "P", "M", "c", "C", "w", "W", "K", "k": c = TAG_COLOR;
      "d", "D": c = TAG_BOLD;
      "1", "z", "Z": c = TAG_RESET;
      default: c = TAG_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tag_digit(logic [7:0] t);
    logic [7:0] d;
    case (t)
      "r", "R": d = "1";
      "g", "G": d = "2";
      "b", "B": d = "4";
      "y", "o", "Y", "O": d = "3";
      "p", "m", "P", "M": d = "5";
      "c", "C": d = "6";
      "w", "W": d = "7";
      default: d = "0";
    endcase
    return d;
  endfunction

  function automatic logic [7:0] tag_bright(logic [7:0] t);
    logic [7:0] d;
    if (t == "k") begin
      d = "1";
    end else if (t == "K") begin
      d = "0";
    end else if (t >= "A" && t <= "Z") begin
      d = "1";
    end else begin
      d = "0";
    end
    return d;
  endfunction

  function automatic blk_kind_t blk_kind_of(tag_cls_t c);
    blk_kind_t k;
    case (c)
      TAG_NAME:  k = BLK_NAME;
      TAG_BOLD:  k = BLK_BOLD;
      TAG_RESET: k = BLK_RESET;
      default:   k = BLK_COLOR;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] blk_len(blk_kind_t k);
    logic [3:0] n;
    case (k)
      BLK_NAME:  n = 4'd8;
      BLK_COLOR: n = 4'd7;
      default:   n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] blk_byte(blk_kind_t k, logic [7:0] t, logic [2:0] idx);
    logic [7:0] b;
    b = CH_ESC;
    case (k)
      BLK_NAME: begin
        b = BANNER[idx];
      end
      BLK_COLOR: begin
        case (idx)
          3'd0: b = CH_ESC;
          3'd1: b = "[";
          3'd2: b = tag_bright(t);
          3'd3: b = ";";
          3'd4: b = "3";
          3'd5: b = tag_digit(t);
          default: b = "m";
        endcase
      end
      default: begin
        case (idx)
          3'd0: b = CH_ESC;
          3'd1: b = "[";
          3'd2: b = (k == BLK_BOLD) ? 8'("1") : 8'("0");
          default: b = "m";
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mtat_dp.sv @@
// Datapath of the tag translator: window, counters, held-break memory,
// escape generation, configuration registers and the output register.
// Depends on mtat_pkg; driven by commands from mtat_ctrl.
`default_nettype none

module mtat_dp #(
  parameter int HOLD_DEPTH = mtat_pkg::HOLD_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mtat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtat_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mtat_pkg::in_item_t              in_data,
  input  mtat_pkg::cmd_t                  cmd,
  output mtat_pkg::stat_t                 stat,
  input  logic                            out_stall,
  output logic                            out_valid,
  output mtat_pkg::out_item_t             out_data
);
  import mtat_pkg::*;

  localparam int HCW = $clog2(HOLD_DEPTH + 1);
  localparam int HIW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  logic              color_en_r, color_en_nxt;
  logic [15:0]       cap_r, cap_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [7:0]        win0_r, win0_nxt;
  logic [7:0]        win1_r, win1_nxt;
  logic [1:0]        wcnt_r, wcnt_nxt;
  logic [7:0]        tag_r, tag_nxt;
  logic [7:0]        lit_r, lit_nxt;
  logic [15:0]       written_r, written_nxt;
  logic              color_open_r, color_open_nxt;
  logic [HCW-1:0]    held_cnt_r, held_cnt_nxt;
  logic [HCW-1:0]    fidx_r, fidx_nxt;
  logic              held_rd_r;
  blk_kind_t         blk_kind_r, blk_kind_nxt;
  logic [2:0]        blk_idx_r, blk_idx_nxt;
  logic [RES_CW-1:0] res_cnt_r, res_cnt_nxt;
  logic              o_vld_r, o_vld_nxt;
  out_item_t         o_data_r, o_data_nxt;

  logic              held_mem [HOLD_DEPTH];

  tag_cls_t          tag_cls;
  logic [3:0]        cur_len;
  logic              put_any;
  logic              put_keep;
  out_item_t         put_item;

  assign tag_cls  = tag_classify(tag_r);
  assign cur_len  = blk_len(blk_kind_r);
  assign put_any  = cmd.flush_put | cmd.lit_put | cmd.blk_put | cmd.end_put;
  assign put_keep = put_any && (res_cnt_r < RES_CW'(MAX_RESULTS));

  always_comb begin
    put_item.out_valid    = 1'b1;
    put_item.out_last     = 1'b0;
    put_item.total_length = 16'd0;
    put_item.out_byte     = lit_r;
    if (cmd.end_put) begin
      put_item.out_valid    = 1'b0;
      put_item.out_byte     = 8'd0;
      put_item.out_last     = 1'b1;
      put_item.total_length = written_r;
    end else if (cmd.flush_put) begin
      put_item.out_byte = held_rd_r ? CH_CR : CH_LF;
    end else if (cmd.blk_put) begin
      put_item.out_byte = blk_byte(blk_kind_r, tag_r, blk_idx_r);
    end
  end

  always_comb begin
    color_en_nxt   = color_en_r;
    cap_nxt        = cap_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    win0_nxt       = win0_r;
    win1_nxt       = win1_r;
    wcnt_nxt       = wcnt_r;
    tag_nxt        = tag_r;
    lit_nxt        = lit_r;
    written_nxt    = written_r;
    color_open_nxt = color_open_r;
    held_cnt_nxt   = held_cnt_r;
    fidx_nxt       = fidx_r;
    blk_kind_nxt   = blk_kind_r;
    blk_idx_nxt    = blk_idx_r;
    res_cnt_nxt    = res_cnt_r;
    o_vld_nxt      = o_vld_r;
    o_data_nxt     = o_data_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_COLOR_ENABLE: color_en_nxt = cfg_data[0];
        CFG_OUT_CAPACITY: cap_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load_item) begin
      byte_nxt    = in_data.in_byte;
      last_nxt    = in_data.in_last;
      res_cnt_nxt = '0;
    end
    if (cmd.win_store) begin
      if (wcnt_r == 2'd0) begin
        win0_nxt = byte_r;
      end else begin
        win1_nxt = byte_r;
      end
      wcnt_nxt = wcnt_r + 2'd1;
    end
    if (cmd.win_shift) begin
      win0_nxt = win1_r;
      win1_nxt = byte_r;
    end
    if (cmd.tag_latch) begin
      tag_nxt  = win1_r;
      wcnt_nxt = 2'd0;
    end
    if (cmd.lit_load) begin
      case (cmd.lit_sel)
        LIT_LT:  lit_nxt = CH_LT;
        LIT_GT:  lit_nxt = CH_GT;
        LIT_TAG: lit_nxt = tag_r;
        LIT_W0:  lit_nxt = win0_r;
        LIT_W1:  lit_nxt = win1_r;
        default: lit_nxt = lit_r;
      endcase
    end
    if (cmd.lit_commit) begin
      written_nxt = written_r + 16'd1;
    end
    if (cmd.held_push) begin
      held_cnt_nxt = held_cnt_r + HCW'(1);
    end
    if (cmd.flush_put) begin
      fidx_nxt = fidx_r + HCW'(1);
    end
    if (cmd.flush_done) begin
      held_cnt_nxt = '0;
      fidx_nxt     = '0;
    end
    if (cmd.blk_start) begin
      blk_kind_nxt = blk_kind_of(tag_cls);
      blk_idx_nxt  = 3'd0;
    end
    if (cmd.blk_final) begin
      blk_kind_nxt = BLK_RESET;
      blk_idx_nxt  = 3'd0;
    end
    if (cmd.color_update) begin
      color_open_nxt = (tag_cls != TAG_RESET);
    end
    if (cmd.blk_commit) begin
      written_nxt = written_r + {12'd0, cur_len};
    end
    if (cmd.blk_put) begin
      blk_idx_nxt = blk_idx_r + 3'd1;
    end

    if (o_vld_r && !out_stall) begin
      o_vld_nxt = 1'b0;
    end
    if (put_keep) begin
      o_vld_nxt   = 1'b1;
      o_data_nxt  = put_item;
      res_cnt_nxt = res_cnt_r + RES_CW'(1);
    end

    if (cmd.end_put) begin
      wcnt_nxt       = 2'd0;
      written_nxt    = 16'd0;
      color_open_nxt = 1'b0;
      held_cnt_nxt   = '0;
      fidx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_en_r   <= 1'b1;
      cap_r        <= 16'hFFFF;
      wcnt_r       <= 2'd0;
      written_r    <= 16'd0;
      color_open_r <= 1'b0;
      held_cnt_r   <= '0;
      fidx_r       <= '0;
      res_cnt_r    <= '0;
      o_vld_r      <= 1'b0;
    end else begin
      color_en_r   <= color_en_nxt;
      cap_r        <= cap_nxt;
      wcnt_r       <= wcnt_nxt;
      written_r    <= written_nxt;
      color_open_r <= color_open_nxt;
      held_cnt_r   <= held_cnt_nxt;
      fidx_r       <= fidx_nxt;
      res_cnt_r    <= res_cnt_nxt;
      o_vld_r      <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    win0_r     <= win0_nxt;
    win1_r     <= win1_nxt;
    tag_r      <= tag_nxt;
    lit_r      <= lit_nxt;
    blk_kind_r <= blk_kind_nxt;
    blk_idx_r  <= blk_idx_nxt;
    o_data_r   <= o_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.held_push) begin
      held_mem[held_cnt_r[HIW-1:0]] <= (lit_r == CH_CR);
    end
    held_rd_r <= held_mem[fidx_r[HIW-1:0]];
  end

  assign stat.wcnt         = wcnt_r;
  assign stat.win_tag      = (wcnt_r == 2'd2) && (win0_r == CH_LT) && (byte_r == CH_GT);
  assign stat.last         = last_r;
  assign stat.tag_cls      = tag_cls;
  assign stat.color_en     = color_en_r;
  assign stat.lit_fits     = ({1'b0, written_r} + 17'd1) < {1'b0, cap_r};
  assign stat.lit_break    = (lit_r == CH_LF) || (lit_r == CH_CR);
  assign stat.held_full    = held_cnt_r >= HCW'(HOLD_DEPTH);
  assign stat.held_pending = fidx_r < held_cnt_r;
  assign stat.blk_fits     = ({1'b0, written_r} + {13'd0, cur_len}) < {1'b0, cap_r};
  assign stat.blk_last     = blk_idx_r == 3'(cur_len - 4'd1);
  assign stat.reset_fits   = color_open_r && (({1'b0, written_r} + 17'd4) < {1'b0, cap_r});
  assign stat.out_free     = !o_vld_r || !out_stall;

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

`default_nettype wire

@@ rtl/core/mtat_ctrl.sv @@
// Controller of the tag translator: sequences window decisions, literal
// and escape emission, break flushing and the end marker.
// Depends on mtat_pkg; drives mtat_dp through command and status structs.
`default_nettype none

module mtat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mtat_pkg::stat_t stat,
  output mtat_pkg::cmd_t  cmd
);
  import mtat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_TAG,
    S_LIT,
    S_FLUSH,
    S_FLUSH_PUT,
    S_PUSH,
    S_PUT_LIT,
    S_BLK_CHK,
    S_BLK_PUT,
    S_RET,
    S_TAIL,
    S_RST_CHK,
    S_END
  } state_t;

  typedef enum logic [2:0] {
    J_TAG_T,
    J_TAG_GT,
    J_STEP_DONE,
    J_TAIL1,
    J_TAIL_DONE,
    J_RST_DONE
  } job_t;

  typedef enum logic [1:0] {
    AF_PUSH,
    AF_LIT,
    AF_BLK,
    AF_END
  } after_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  after_t after_r, after_nxt;
  logic   noflush_r, noflush_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    job_nxt     = job_r;
    after_nxt   = after_r;
    noflush_nxt = noflush_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_WIN;
        end
      end
      S_WIN: begin
        if (stat.wcnt != 2'd2) begin
          cmd.win_store = 1'b1;
          state_nxt     = S_TAIL;
        end else if (stat.win_tag) begin
          cmd.tag_latch = 1'b1;
          state_nxt     = S_TAG;
        end else begin
          cmd.lit_load  = 1'b1;
          cmd.lit_sel   = LIT_W0;
          cmd.win_shift = 1'b1;
          job_nxt       = J_STEP_DONE;
          state_nxt     = S_LIT;
        end
      end
      S_TAG: begin
        if (stat.tag_cls == TAG_UNKNOWN) begin
          cmd.lit_load = 1'b1;
          cmd.lit_sel  = LIT_LT;
          job_nxt      = J_TAG_T;
          state_nxt    = S_LIT;
        end else if (stat.color_en) begin
          cmd.blk_start    = 1'b1;
          cmd.color_update = (stat.tag_cls != TAG_NAME);
          noflush_nxt      = 1'b0;
          job_nxt          = J_STEP_DONE;
          state_nxt        = S_BLK_CHK;
        end else begin
          state_nxt = S_TAIL;
        end
      end
      S_LIT: begin
        if (!stat.lit_fits) begin
          state_nxt = S_RET;
        end else begin
          cmd.lit_commit = 1'b1;
          if (stat.lit_break) begin
            if (stat.held_full) begin
              after_nxt = AF_PUSH;
              state_nxt = S_FLUSH;
            end else begin
              cmd.held_push = 1'b1;
              state_nxt     = S_RET;
            end
          end else if (stat.held_pending) begin
            after_nxt = AF_LIT;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_PUT_LIT;
          end
        end
      end
      S_FLUSH: begin
        if (stat.held_pending) begin
          state_nxt = S_FLUSH_PUT;
        end else begin
          cmd.flush_done = 1'b1;
          case (after_r)
            AF_PUSH: state_nxt = S_PUSH;
            AF_LIT:  state_nxt = S_PUT_LIT;
            AF_BLK:  state_nxt = S_BLK_PUT;
            default: state_nxt = S_END;
          endcase
        end
      end
      S_FLUSH_PUT: begin
        if (stat.out_free) begin
          cmd.flush_put = 1'b1;
          state_nxt     = S_FLUSH;
        end
      end
      S_PUSH: begin
        cmd.held_push = 1'b1;
        state_nxt     = S_RET;
      end
      S_PUT_LIT: begin
        if (stat.out_free) begin
          cmd.lit_put = 1'b1;
          state_nxt   = S_RET;
        end
      end
      S_BLK_CHK: begin
        if (!stat.blk_fits) begin
          state_nxt = S_RET;
        end else begin
          cmd.blk_commit = 1'b1;
          if (noflush_r || !stat.held_pending) begin
            state_nxt = S_BLK_PUT;
          end else begin
            after_nxt = AF_BLK;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_BLK_PUT: begin
        if (stat.out_free) begin
          cmd.blk_put = 1'b1;
          if (stat.blk_last) begin
            state_nxt = S_RET;
          end
        end
      end
      S_RET: begin
        case (job_r)
          J_TAG_T: begin
            cmd.lit_load = 1'b1;
            cmd.lit_sel  = LIT_TAG;
            job_nxt      = J_TAG_GT;
            state_nxt    = S_LIT;
          end
          J_TAG_GT: begin
            cmd.lit_load = 1'b1;
            cmd.lit_sel  = LIT_GT;
            job_nxt      = J_STEP_DONE;
            state_nxt    = S_LIT;
          end
          J_TAIL1: begin
            cmd.lit_load = 1'b1;
            cmd.lit_sel  = LIT_W1;
            job_nxt      = J_TAIL_DONE;
            state_nxt    = S_LIT;
          end
          J_TAIL_DONE: begin
            state_nxt = S_RST_CHK;
          end
          J_RST_DONE: begin
            after_nxt = AF_END;
            state_nxt = S_FLUSH;
          end
          default: begin
            state_nxt = S_TAIL;
          end
        endcase
      end
      S_TAIL: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.wcnt == 2'd0) begin
          state_nxt = S_RST_CHK;
        end else begin
          cmd.lit_load = 1'b1;
          cmd.lit_sel  = LIT_W0;
          job_nxt      = (stat.wcnt == 2'd2) ? J_TAIL1 : J_TAIL_DONE;
          state_nxt    = S_LIT;
        end
      end
      S_RST_CHK: begin
        if (stat.reset_fits) begin
          cmd.blk_final = 1'b1;
          noflush_nxt   = 1'b1;
          job_nxt       = J_RST_DONE;
          state_nxt     = S_BLK_CHK;
        end else begin
          after_nxt = AF_END;
          state_nxt = S_FLUSH;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.end_put = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      job_r     <= J_STEP_DONE;
      after_r   <= AF_END;
      noflush_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      job_r     <= job_nxt;
      after_r   <= after_nxt;
      noflush_r <= noflush_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/markup_tag_to_ansi_translator_unit.sv @@
// Top level of the markup tag to ANSI escape translator.
// Depends on mtat_pkg, mtat_ctrl, mtat_dp and assert_macros.svh.
//
// The block takes one message byte per request and handles one request at a
// time, so the input stalls until the controller is back in idle. A byte may
// only enter the window, or push the oldest window byte out as text, which is
// held when it is a CR or LF and dropped for lack of room. A known tag with
// color on emits its escape or name, or is dropped for lack of room; with
// color off it is dropped. An unknown tag goes out as text with its brackets.
// Flushing held breaks reads the held-break memory through a registered read
// port. The final byte of a message emits each leftover window byte, the
// closing reset escape and the end marker. A put waits while the output
// stalls. Configuration writes are always ready and must only be issued
// between messages or while no request is in work.
`default_nettype none

module markup_tag_to_ansi_translator_unit #(
  parameter int HOLD_DEPTH = mtat_pkg::HOLD_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mtat_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mtat_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mtat_pkg::*;

  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;
  logic  any_put;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign any_put   = cmd.lit_put | cmd.blk_put | cmd.flush_put | cmd.end_put;

  mtat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtat_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `ASSERT_SAME(a_put_needs_free, any_put, stat.out_free)
  `ASSERT_SAME(a_push_not_full, cmd.held_push, !stat.held_full)
  `ASSERT_SAME(a_commit_fits, cmd.lit_commit, stat.lit_fits)
  `ASSERT_NEXT(a_end_clears, cmd.end_put, (stat.wcnt == 2'd0) && !stat.held_pending)

endmodule

`default_nettype wire

@@ tb/markup_tag_to_ansi_translator_unit_tb.sv @@
// Self-checking testbench for the markup tag to ANSI translator top level.
// A built-in predictor works out the output bytes of every accepted request.
// Depends on mtat_pkg and markup_tag_to_ansi_translator_unit.
`default_nettype none

module markup_tag_to_ansi_translator_unit_tb;
  import mtat_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  localparam int HOLD = HOLD_DEPTH_DEF;
  localparam int ITEM_TARGET = 330;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int MAX_PRINTED = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
  localparam logic [15:0] CAPACITY_FULL = 16'hFFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  in_item_t    source_q[$];
  out_item_t   translated_q[$];
  logic [7:0]  msg[$];
  string       tag_letters = "rRgGbByoYOpmPMcCwWKkdD1zZhH";

  int          err_count;
  int          cycle_count;
  int          sent_total;
  int          burst_left;
  int          gap_left;
  int          stall_phase;
  int          hold_left;
  logic        hold_request;
  stall_mode_t stall_mode;
  out_item_t   want;

  // Predictor state and its copy of the registers.
  logic        pred_color_en;
  int unsigned pred_capacity;
  logic [7:0]  win [2];
  int          win_n;
  int unsigned wr_count;
  logic        esc_open;
  logic        held_cr [HOLD];
  int          held_n;
  int          step_results;

  markup_tag_to_ansi_translator_unit #(.HOLD_DEPTH(HOLD)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_message_state();
    win[0] = '0;
    win[1] = '0;
    win_n = 0;
    wr_count = 0;
    esc_open = 1'b0;
    held_n = 0;
  endfunction

  function automatic void push_result(logic v, logic [7:0] b, logic l, logic [15:0] tot);
    out_item_t r;
    if (step_results >= MAX_RESULTS) begin
      return;
    end
    r.out_valid = v;
    r.out_byte = b;
    r.out_last = l;
    r.total_length = tot;
    translated_q.push_back(r);
    step_results++;
  endfunction

  function automatic void flush_breaks();
    int i;
    for (i = 0; i < held_n; i++) begin
      push_result(1'b1, held_cr[i] ? CH_CR : CH_LF, 1'b0, 16'd0);
    end
    held_n = 0;
  endfunction

  function automatic void put_text(logic [7:0] b);
    if (wr_count + 1 >= pred_capacity) begin
      return;
    end
    wr_count++;
    if (b == CH_LF || b == CH_CR) begin
      if (held_n >= HOLD) begin
        flush_breaks();
      end
      held_cr[held_n] = (b == CH_CR);
      held_n++;
    end else begin
      flush_breaks();
      push_result(1'b1, b, 1'b0, 16'd0);
    end
  endfunction

  function automatic void put_block(logic [63:0] seq, int len);
    int i;
    if (wr_count + len >= pred_capacity) begin
      return;
    end
    flush_breaks();
    for (i = 0; i < len; i++) begin
      push_result(1'b1, seq[8*i +: 8], 1'b0, 16'd0);
    end
    wr_count += len;
  endfunction

  // Returns the escape length for tag t, or zero when the tag is unknown or is the name tag.
  function automatic int tag_escape(input logic [7:0] t, output logic [63:0] seq);
    logic [7:0] digit;
    logic [7:0] bright;
    seq = '0;
    digit = "0";
    case (t)
      "r", "R": digit = "1";
      "g", "G": digit = "2";
      "b", "B": digit = "4";
      "y", "o", "Y", "O": digit = "3";
      "p", "m", "P", "M": digit = "5";
      "c", "C": digit = "6";
      "w", "W": digit = "7";
      "K", "k": digit = "0";
      "d", "D": begin
        seq = {32'd0, "m", "1", "[", CH_ESC};
        return 4;
      end
      "1", "z", "Z": begin
        seq = {32'd0, "m", "0", "[", CH_ESC};
        return 4;
      end
      default: return 0;
    endcase
    if (t == "k") begin
      bright = "1";
    end else if (t == "K") begin
      bright = "0";
    end else begin
      bright = (t >= "A" && t <= "Z") ? 8'("1") : 8'("0");
    end
    seq = {8'd0, "m", digit, "3", ";", bright, "[", CH_ESC};
    return 7;
  endfunction

  function automatic void apply_tag(logic [7:0] t);
    logic [63:0] seq;
    int len;
    int i;
    if (t == "h" || t == "H") begin
      if (pred_color_en) begin
        for (i = 0; i < 8; i++) begin
          seq[8*i +: 8] = BANNER[i];
        end
        put_block(seq, 8);
      end
      return;
    end
    len = tag_escape(t, seq);
    if (len != 0) begin
      if (pred_color_en) begin
        put_block(seq, len);
        esc_open = (len != 4) || (seq[31:0] != {"m", "0", "[", CH_ESC});
      end
      return;
    end
    put_text(CH_LT);
    put_text(t);
    put_text(CH_GT);
  endfunction

  function automatic void translate_byte(in_item_t it);
    int i;
    step_results = 0;
    if (win_n >= 2) begin
      if (win[0] == CH_LT && it.in_byte == CH_GT) begin
        apply_tag(win[1]);
        win_n = 0;
      end else begin
        put_text(win[0]);
        win[0] = win[1];
        win[1] = it.in_byte;
      end
    end else begin
      win[win_n] = it.in_byte;
      win_n++;
    end
    if (it.in_last) begin
      for (i = 0; i < win_n; i++) begin
        put_text(win[i]);
      end
      win_n = 0;
      if (esc_open && wr_count + 4 < pred_capacity) begin
        push_result(1'b1, CH_ESC, 1'b0, 16'd0);
        push_result(1'b1, "[", 1'b0, 16'd0);
        push_result(1'b1, "0", 1'b0, 16'd0);
        push_result(1'b1, "m", 1'b0, 16'd0);
        wr_count += 4;
      end
      flush_breaks();
      push_result(1'b0, 8'd0, 1'b1, wr_count[15:0]);
      clear_message_state();
    end
  endfunction

  // ------------------------------------------------------------ shared tasks

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("[%0d] mismatch: %s", cycle_count, what);
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    source_q.push_back(it);
    sent_total++;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg.size(); i++) begin
      send_item(msg[i], i == msg.size() - 1);
    end
    msg.delete();
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      msg.push_back(s[i]);
    end
  endtask

  task automatic add_breaks(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      msg.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
  endtask

  task automatic build_random_message();
    int target;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    while (msg.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          msg.push_back(CH_LT);
          if ($urandom_range(0, 4) == 0) begin
            msg.push_back(8'($urandom_range(1, 255)));
          end else begin
            msg.push_back(tag_letters[$urandom_range(0, tag_letters.len() - 1)]);
          end
          msg.push_back(CH_GT);
        end
        4: add_breaks($urandom_range(1, 3));
        5: msg.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
        6: msg.push_back(8'($urandom_range(1, 255)));
        default: msg.push_back(8'($urandom_range(32, 126)));
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      add_breaks($urandom_range(1, 4));
    end
    send_message();
  endtask

  task automatic wait_drained();
    while (source_q.size() != 0 || in_valid || translated_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    if (idx == CFG_COLOR_ENABLE) begin
      pred_color_en = value[0];
    end else if (idx == CFG_OUT_CAPACITY) begin
      pred_capacity = value;
    end
  endtask

  // ------------------------------------------------------------ bus processes

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        translate_byte(in_data);
        void'(source_q.pop_front());
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (source_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= source_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_phase = 0;
      stall_mode = STALL_NONE;
    end else begin
      if (hold_request) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_phase == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_phase = $urandom_range(16, 80);
      end else begin
        stall_phase--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (translated_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                  out_data.out_byte, out_data.out_last));
      end else begin
        want = translated_q.pop_front();
        if (out_data.out_valid !== want.out_valid) begin
          report_mismatch($sformatf("out_valid got %0b want %0b",
                                    out_data.out_valid, want.out_valid));
        end
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte got %02h want %02h",
                                    out_data.out_byte, want.out_byte));
        end
        if (out_data.out_last !== want.out_last) begin
          report_mismatch($sformatf("out_last got %0b want %0b",
                                    out_data.out_last, want.out_last));
        end
        if (out_data.total_length !== want.total_length) begin
          report_mismatch($sformatf("total_length got %0d want %0d",
                                    out_data.total_length, want.total_length));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------- test tasks

  task automatic test_plain_text_and_tags();
    add_text("<r>A");
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
    send_message();
    msg.push_back(8'hFF);
    msg.push_back(8'h01);
    send_message();
    add_text("<q>");
    send_message();
    add_text("<h><z>");
    send_message();
    add_text("<<b>>");
    send_message();
    msg.push_back(CH_LF);
    send_message();
    wait_drained();
  endtask

  task automatic test_every_tag();
    int i;
    for (i = 0; i < tag_letters.len(); i++) begin
      msg.push_back(CH_LT);
      msg.push_back(tag_letters[i]);
      msg.push_back(CH_GT);
      if (i % 6 == 5 || i == tag_letters.len() - 1) begin
        add_text("x");
        send_message();
      end
    end
    wait_drained();
  endtask

  task automatic test_color_disabled();
    int i;
    write_register(CFG_COLOR_ENABLE, '0);
    for (i = 0; i < 4; i++) begin
      build_random_message();
    end
    write_register(CFG_COLOR_ENABLE, CFG_DATA_W'(1));
  endtask

  task automatic test_capacity_limits();
    logic [15:0] caps [10];
    int i;
    caps = '{16'd0, 16'd1, 16'd2, 16'd4, 16'd5, 16'd8, 16'd9, 16'd12, 16'd20, CAPACITY_FULL};
    for (i = 0; i < 10; i++) begin
      write_register(CFG_OUT_CAPACITY, caps[i]);
      write_register(CFG_COLOR_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
      add_text("<R>ab<h>");
      add_breaks(2);
      send_message();
    end
    write_register(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
    write_register(CFG_COLOR_ENABLE, CFG_DATA_W'(1));
    build_random_message();
    wait_drained();
  endtask

  task automatic test_break_holding();
    add_text("<g>");
    add_breaks(HOLD + 4);
    add_text("x");
    add_breaks(HOLD + 2);
    send_message();
    add_breaks(HOLD + 1);
    send_message();
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int i;
    hold_request = 1'b1;
    for (i = 0; i < 3; i++) begin
      add_text("<W>");
      build_random_message();
    end
    wait_drained();
  endtask

  task automatic test_random_messages();
    int count;
    count = 0;
    while (sent_total < ITEM_TARGET) begin
      if (count % 8 == 7) begin
        write_register(CFG_COLOR_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
        write_register(CFG_OUT_CAPACITY, ($urandom_range(0, 1) == 0) ?
                       CFG_DATA_W'($urandom_range(0, 40)) : CAPACITY_FULL);
      end
      build_random_message();
      count++;
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    err_count = 0;
    cycle_count = 0;
    sent_total = 0;
    pred_color_en = 1'b1;
    pred_capacity = 65535;
    clear_message_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_text_and_tags();
    test_every_tag();
    test_color_disabled();
    test_capacity_limits();
    test_break_holding();
    test_output_backpressure();
    test_random_messages();

    wait_drained();
    if (translated_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", translated_q.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
